>>> hdl/q2e_pkg.sv
// Shared constants and tables for the quaternion to Euler angle converter.
// Used by the top level, the arctangent pipeline and the square root pipeline.
package q2e_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int FRACTION_BITS_DEF = 14;

	// Angles are carried at 30 fraction bits inside the pipelines.
	localparam int ANG_FRAC = 30;
	localparam int TABLE_LEN = 24;

	// Rotator datapath width and angle accumulator width.
	localparam int CW = 34;
	localparam int ZW = 35;

	// Square root pipeline: radicand width and number of result bits.
	localparam int RW = 62;
	localparam int ISQ_STAGES = ANG_FRAC + 1;

	localparam int PI_Q13 = 25736;
	localparam int HALF_PI_Q13 = 12868;

	localparam logic signed [ZW-1:0] PI_Q30 = 35'sd3373259426;

	// atan(2^-i) at 30 fraction bits.
	localparam logic signed [ZW-1:0] ATAN_TAB [TABLE_LEN] = '{
		35'sd843314856, 35'sd497837829, 35'sd263043836, 35'sd133525158,
		35'sd67021686, 35'sd33543515, 35'sd16775850, 35'sd8388437,
		35'sd4194282, 35'sd2097149, 35'sd1048575, 35'sd524287,
		35'sd262143, 35'sd131071, 35'sd65535, 35'sd32767,
		35'sd16383, 35'sd8191, 35'sd4095, 35'sd2047,
		35'sd1023, 35'sd511, 35'sd255, 35'sd127
	};

endpackage

>>> hdl/q2e_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on q2e_pkg for the radicand width and the stage count.
module q2e_isqrt (
	input  logic                                clk,
	input  logic                                en,
	input  logic [q2e_pkg::RW-1:0]              rad,
	output logic [q2e_pkg::ISQ_STAGES-1:0]      root
);

	localparam int RW = q2e_pkg::RW;
	localparam int NS = q2e_pkg::ISQ_STAGES;

	logic [RW-1:0] v_s [1:NS];
	logic [RW-1:0] r_s [1:NS];

	for (genvar j = 0; j < NS; j++) begin : g_stage
		localparam logic [RW-1:0] BIT = RW'(1) << (2 * (NS - 1 - j));
		logic [RW-1:0] v_in, r_in;
		logic [RW-1:0] trial;

		// The first stage works on the radicand with a zero partial root.
		if (j == 0) begin : g_first
			assign v_in = rad;
			assign r_in = '0;
		end else begin : g_next
			assign v_in = v_s[j];
			assign r_in = r_s[j];
		end

		assign trial = r_in + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				if (v_in >= trial) begin
					v_s[j+1] <= v_in - trial;
					r_s[j+1] <= (r_in >> 1) + BIT;
				end else begin
					v_s[j+1] <= v_in;
					r_s[j+1] <= r_in >> 1;
				end
			end
		end
	end

	assign root = r_s[NS][NS-1:0];

endmodule

>>> hdl/q2e_atan2.sv
// Pipelined atan2 in vectoring CORDIC form: normalize, fold quadrant, rotate, round.
// Depends on q2e_pkg for the angle table and datapath widths.
module q2e_atan2 #(
	parameter int IW = 34,
	parameter int STAGES = q2e_pkg::CORDIC_STAGES_DEF,
	parameter int LIM = q2e_pkg::PI_Q13
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [IW-1:0] in_a,
	input  logic signed [IW-1:0] in_b,
	output logic signed [15:0]   ang
);

	localparam int CW = q2e_pkg::CW;
	localparam int ZW = q2e_pkg::ZW;
	localparam int N = (STAGES < q2e_pkg::TABLE_LEN) ? STAGES : q2e_pkg::TABLE_LEN;
	localparam int PW = $clog2(IW);
	localparam int EW = IW + 30;
	localparam logic [PW-1:0] P29 = PW'(29);
	localparam logic signed [17:0] LIMS = 18'(LIM);

	// Stage 1: magnitudes folded into one word for the leading one search.
	logic signed [IW-1:0] a_s1, b_s1;
	logic [IW-1:0] om_s1;
	logic [IW-1:0] ma, mb;

	assign ma = in_a[IW-1] ? IW'(-in_a) : IW'(in_a);
	assign mb = in_b[IW-1] ? IW'(-in_b) : IW'(in_b);

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1 <= in_a;
			b_s1 <= in_b;
			om_s1 <= ma | mb;
		end
	end

	// Stage 2: position of the leading one.
	logic signed [IW-1:0] a_s2, b_s2;
	logic [PW-1:0] p_s2;
	logic zero_s2;
	logic [PW-1:0] pos;

	always_comb begin
		pos = '0;
		for (int i = 0; i < IW; i++) begin
			if (om_s1[i]) pos = PW'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s2 <= a_s1;
			b_s2 <= b_s1;
			p_s2 <= pos;
			zero_s2 <= (om_s1 == '0);
		end
	end

	// Stage 3: shift so that the larger magnitude lies in [2^29, 2^30).
	logic signed [CW-1:0] a_s3, b_s3;
	logic zero_s3;
	logic signed [EW-1:0] ea, eb, sa, sb;

	always_comb begin
		ea = EW'(a_s2);
		eb = EW'(b_s2);
		if (p_s2 > P29) begin
			sa = ea >>> (p_s2 - P29);
			sb = eb >>> (p_s2 - P29);
		end else begin
			sa = ea <<< (P29 - p_s2);
			sb = eb <<< (P29 - p_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s3 <= sa[CW-1:0];
			b_s3 <= sb[CW-1:0];
			zero_s3 <= zero_s2;
		end
	end

	// Stage 4 and the rotator stages share these arrays; index 0 is the folded input.
	logic signed [CW-1:0] ca [0:N];
	logic signed [CW-1:0] cb [0:N];
	logic signed [ZW-1:0] cz [0:N];
	logic                 czero [0:N];

	always_ff @(posedge clk) begin
		if (en) begin
			czero[0] <= zero_s3;
			if (b_s3 < 0) begin
				cz[0] <= (a_s3 >= 0) ? q2e_pkg::PI_Q30 : -q2e_pkg::PI_Q30;
				ca[0] <= -a_s3;
				cb[0] <= -b_s3;
			end else begin
				cz[0] <= '0;
				ca[0] <= a_s3;
				cb[0] <= b_s3;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_rot
		logic signed [CW-1:0] da, db;

		assign da = ca[i] >>> i;
		assign db = cb[i] >>> i;

		always_ff @(posedge clk) begin
			if (en) begin
				czero[i+1] <= czero[i];
				if (ca[i] >= 0) begin
					cb[i+1] <= cb[i] + da;
					ca[i+1] <= ca[i] - db;
					cz[i+1] <= cz[i] + q2e_pkg::ATAN_TAB[i];
				end else begin
					cb[i+1] <= cb[i] - da;
					ca[i+1] <= ca[i] + db;
					cz[i+1] <= cz[i] - q2e_pkg::ATAN_TAB[i];
				end
			end
		end
	end

	// Final stage: round half up to 13 fraction bits and clamp.
	logic signed [ZW-1:0] zr;
	logic signed [17:0] q, qc;

	assign zr = cz[N] + ZW'(1 << 16);
	assign q = zr[ZW-1:17];

	always_comb begin
		qc = q;
		if (q > LIMS) qc = LIMS;
		if (q < -LIMS) qc = -LIMS;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang <= czero[N] ? '0 : qc[15:0];
		end
	end

endmodule

>>> hdl/quaternion_to_euler_angles_unit.sv
// Top level of the quaternion to Euler angle converter (Z-Y-X order).
// Depends on q2e_pkg, q2e_atan2 and q2e_isqrt.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------
//   input   | in        | in_valid / in_stall  | quat_x, quat_y, quat_z, quat_w
//   output  | out       | out_valid / out_stall| roll_angle, pitch_angle, yaw_angle,
//           |           |                      | pitch_saturated
//
// One word enters per cycle unless in_stall is high; CORDIC_STAGES is capped at 24.
// The pitch path sets the latency: its 31-stage square root runs before its CORDIC.
// Reset clears only the valid bits; the data registers are not reset.
// A stalled output word freezes the whole pipeline, and in_stall follows at once.
module quaternion_to_euler_angles_unit #(
	parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF,
	parameter int FRACTION_BITS = q2e_pkg::FRACTION_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic signed [15:0] quat_w,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] roll_angle,
	output logic signed [14:0] pitch_angle,
	output logic signed [15:0] yaw_angle,
	output logic               pitch_saturated
);

	localparam int F2 = 2 * FRACTION_BITS;
	localparam int SW = (F2 + 2 > 34) ? F2 + 2 : 34;
	localparam int N = (CORDIC_STAGES < q2e_pkg::TABLE_LEN) ? CORDIC_STAGES
		: q2e_pkg::TABLE_LEN;
	localparam int LA = N + 5;
	localparam int NSQ = q2e_pkg::ISQ_STAGES;
	localparam int T = 4 + NSQ + LA;
	localparam int RDLY = T - 2 - LA;
	localparam int PIW = q2e_pkg::ANG_FRAC + 3;
	localparam int RW = q2e_pkg::RW;
	localparam logic signed [SW-1:0] ONE2 = SW'(1) <<< F2;
	localparam logic signed [14:0] HALF = 15'(q2e_pkg::HALF_PI_Q13);

	logic en;
	logic [T:1] vld;

	assign en = !(vld[T] && out_stall);
	assign in_stall = !en;
	assign out_valid = vld[T];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else if (en) begin
			vld <= {vld[T-1:1], in_valid};
		end
	end

	// Stage 1: the nine products.
	logic signed [31:0] wx_s1, yz_s1, xx_s1, yy_s1, wz_s1, xy_s1, zz_s1, wy_s1, zx_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= quat_w * quat_x;
			yz_s1 <= quat_y * quat_z;
			xx_s1 <= quat_x * quat_x;
			yy_s1 <= quat_y * quat_y;
			wz_s1 <= quat_w * quat_z;
			xy_s1 <= quat_x * quat_y;
			zz_s1 <= quat_z * quat_z;
			wy_s1 <= quat_w * quat_y;
			zx_s1 <= quat_z * quat_x;
		end
	end

	// Stage 2: sine and cosine terms at twice the input fraction bits.
	logic signed [SW-1:0] sr_s2, cr_s2, sy_s2, cy_s2, sp_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			sr_s2 <= (SW'(wx_s1) + SW'(yz_s1)) <<< 1;
			cr_s2 <= ONE2 - ((SW'(xx_s1) + SW'(yy_s1)) <<< 1);
			sy_s2 <= (SW'(wz_s1) + SW'(xy_s1)) <<< 1;
			cy_s2 <= ONE2 - ((SW'(yy_s1) + SW'(zz_s1)) <<< 1);
			sp_s2 <= (SW'(wy_s1) - SW'(zx_s1)) <<< 1;
		end
	end

	// Roll and yaw go straight into their arctangent pipelines.
	logic signed [15:0] roll_raw, yaw_raw, pitch_raw;

	q2e_atan2 #(.IW(SW), .STAGES(CORDIC_STAGES), .LIM(q2e_pkg::PI_Q13)) u_roll (
		.clk(clk), .en(en), .in_a(sr_s2), .in_b(cr_s2), .ang(roll_raw)
	);

	q2e_atan2 #(.IW(SW), .STAGES(CORDIC_STAGES), .LIM(q2e_pkg::PI_Q13)) u_yaw (
		.clk(clk), .en(en), .in_a(sy_s2), .in_b(cy_s2), .ang(yaw_raw)
	);

	// Stage 3: saturation test and the pitch sine at 30 fraction bits.
	logic [SW-1:0] msp;
	logic signed [31:0] s30;
	logic signed [31:0] s30_s3;
	logic sat_s3, neg_s3;

	assign msp = sp_s2[SW-1] ? SW'(-sp_s2) : SW'(sp_s2);

	if (F2 >= q2e_pkg::ANG_FRAC) begin : g_sdown
		logic signed [SW-1:0] t;
		assign t = sp_s2 >>> (F2 - q2e_pkg::ANG_FRAC);
		assign s30 = t[31:0];
	end else begin : g_sup
		logic signed [SW-1:0] t;
		assign t = sp_s2 <<< (q2e_pkg::ANG_FRAC - F2);
		assign s30 = t[31:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s30_s3 <= s30;
			sat_s3 <= (msp >= SW'(ONE2));
			neg_s3 <= sp_s2[SW-1];
		end
	end

	// Stage 4: radicand for the pitch cosine, 2^60 - s^2.
	logic [31:0] ms;
	logic [63:0] sq, radw;
	logic [RW-1:0] rad_s4;

	assign ms = s30_s3[31] ? 32'(-s30_s3) : 32'(s30_s3);
	assign sq = 64'(ms) * 64'(ms);
	assign radw = (64'(1) << (2 * q2e_pkg::ANG_FRAC)) - sq;

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s4 <= radw[RW-1:0];
		end
	end

	logic [NSQ-1:0] c30;

	q2e_isqrt u_isqrt (
		.clk(clk), .en(en), .rad(rad_s4), .root(c30)
	);

	// The pitch sine travels beside the square root.
	logic signed [31:0] s30_d [0:NSQ];

	always_ff @(posedge clk) begin
		if (en) begin
			s30_d[0] <= s30_s3;
			for (int k = 1; k <= NSQ; k++) s30_d[k] <= s30_d[k-1];
		end
	end

	q2e_atan2 #(.IW(PIW), .STAGES(CORDIC_STAGES), .LIM(q2e_pkg::HALF_PI_Q13)) u_pitch (
		.clk(clk), .en(en), .in_a(PIW'(s30_d[NSQ])), .in_b(PIW'({1'b0, c30})),
		.ang(pitch_raw)
	);

	// Roll and yaw wait for the longer pitch path.
	logic signed [15:0] roll_d [0:RDLY-1];
	logic signed [15:0] yaw_d [0:RDLY-1];
	logic sat_d [0:T-4];
	logic neg_d [0:T-4];

	always_ff @(posedge clk) begin
		if (en) begin
			roll_d[0] <= roll_raw;
			yaw_d[0] <= yaw_raw;
			for (int k = 1; k < RDLY; k++) begin
				roll_d[k] <= roll_d[k-1];
				yaw_d[k] <= yaw_d[k-1];
			end
			sat_d[0] <= sat_s3;
			neg_d[0] <= neg_s3;
			for (int k = 1; k <= T - 4; k++) begin
				sat_d[k] <= sat_d[k-1];
				neg_d[k] <= neg_d[k-1];
			end
		end
	end

	assign roll_angle = roll_d[RDLY-1];
	assign yaw_angle = yaw_d[RDLY-1];
	assign pitch_saturated = sat_d[T-4];
	assign pitch_angle = sat_d[T-4] ? (neg_d[T-4] ? -HALF : HALF) : pitch_raw[14:0];

endmodule
